/* design/owsm_pkg.sv */
// shared types, widths and constants of the omni wheel speed mixer
package owsm_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int DIV_STEPS    = 15;

    localparam int ANG_W = 20;  // angle in Q16, after heading times 8
    localparam int V_W   = 34;  // cordic vector in Q30
    localparam int P_W   = 50;  // speed times cosine or sine, Q38
    localparam int R_W   = 33;  // rotation times gain, Q25
    localparam int S_W   = 52;  // ratio sum in Q38
    localparam int M_W   = 24;  // ratio magnitude in Q10
    localparam int A_W   = 39;  // ratio magnitude times speed
    localparam int N_W   = 41;  // divider numerator
    localparam int D_W   = 25;  // divider divisor
    localparam int Q_W   = 15;  // quotient magnitude

    localparam logic signed [ANG_W-1:0] ANG_PI      = ANG_W'(205887);
    localparam logic signed [ANG_W-1:0] ANG_HALF_PI = ANG_W'(102944);
    localparam logic signed [V_W-1:0]   CORDIC_START = V_W'(652032874);
    localparam logic [15:0]             GAIN_RESET  = 16'd4096;

    typedef struct packed {
        logic [14:0] speed;
        logic [15:0] heading;
        logic [15:0] rotation;
    } t_cmd;

    typedef struct packed {
        logic [15:0] front_left_speed;
        logic [15:0] front_right_speed;
        logic [15:0] back_left_speed;
        logic [15:0] back_right_speed;
    } t_wheels;

    function automatic logic signed [ANG_W-1:0] atan_q16(input int step);
        logic signed [ANG_W-1:0] v;
        case (step)
            0:       v = ANG_W'(51472);
            1:       v = ANG_W'(30385);
            2:       v = ANG_W'(16055);
            3:       v = ANG_W'(8150);
            4:       v = ANG_W'(4091);
            5:       v = ANG_W'(2047);
            6:       v = ANG_W'(1024);
            7:       v = ANG_W'(512);
            8:       v = ANG_W'(256);
            9:       v = ANG_W'(128);
            10:      v = ANG_W'(64);
            11:      v = ANG_W'(32);
            12:      v = ANG_W'(16);
            13:      v = ANG_W'(8);
            14:      v = ANG_W'(4);
            default: v = ANG_W'(2);
        endcase
        return v;
    endfunction

endpackage

/* design/owsm_cmd_if.sv */
// command channel: speed, heading and rotation
interface owsm_cmd_if;
    logic             valid;
    logic             ready;
    owsm_pkg::t_cmd   payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* design/owsm_wheel_if.sv */
// result channel: four wheel drive values
interface owsm_wheel_if;
    logic              valid;
    logic              ready;
    owsm_pkg::t_wheels payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* design/owsm_cfg_if.sv */
// configuration write channel for the rotation gain
interface owsm_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* design/omni_wheel_speed_mixer.sv */
// omni x drive mixer: cordic, wheel ratios, normalize by largest magnitude
//
//   channel    dir   word
//   i_cmd      in    speed, heading, rotation
//   o_wheels   out   front_left, front_right, back_left, back_right speeds
//   i_cfg      in    rotation_gain, unsigned Q4.12, always ready
//
// one word enters per cycle while no finished word waits on o_wheels; stages: entry
// stage, 16 cordic stages, fold undo, multiply, sum, quantize, max search, divider
// setup, 15 divider stages and the output register.
// reset clears all valid bits and sets the gain to 1.0.
// the whole pipeline holds while a finished word waits on o_wheels.
module omni_wheel_speed_mixer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    owsm_cmd_if.sink            i_cmd,
    owsm_wheel_if.source        o_wheels,
    owsm_cfg_if.sink            i_cfg
);
    import owsm_pkg::*;

    logic w_adv;
    logic [15:0] r_gain;

    // cordic section
    logic                    r_cv [0:CORDIC_STEPS];
    logic signed [V_W-1:0]   r_cx [0:CORDIC_STEPS];
    logic signed [V_W-1:0]   r_cy [0:CORDIC_STEPS];
    logic signed [ANG_W-1:0] r_cz [0:CORDIC_STEPS];
    logic                    r_cf [0:CORDIC_STEPS];
    logic [14:0]             r_cs [0:CORDIC_STEPS];
    logic signed [R_W-1:0]   r_cr [0:CORDIC_STEPS];

    logic signed [ANG_W-1:0] n_ang;
    logic signed [ANG_W-1:0] n_z;
    logic                    n_flip;
    logic signed [R_W-1:0]   n_rot;

    // post cordic
    logic                  r_b_v, r_c_v, r_d_v, r_e_v, r_f_v, r_g_v;
    logic signed [V_W-1:0] r_b_c, r_b_s;
    logic [14:0]           r_b_speed, r_c_speed, r_d_speed, r_e_speed;
    logic signed [R_W-1:0] r_b_r, r_c_r;
    logic signed [P_W-1:0] r_c_x, r_c_y;
    logic signed [S_W-1:0] r_d_sum [0:3];
    logic [M_W-1:0]        r_e_m   [0:3];
    logic                  r_e_neg [0:3];
    logic [A_W-1:0]        r_f_a   [0:3];
    logic                  r_f_neg [0:3];
    logic [M_W-1:0]        r_f_big;
    logic                  r_f_zero;

    logic signed [S_W-1:0] n_rt;
    logic signed [S_W-1:0] n_xe, n_ye;
    logic [S_W-1:0]        n_abs [0:3];
    logic [M_W-1:0]        n_big;

    // divider section
    logic                  r_dv   [0:DIV_STEPS];
    logic [N_W-1:0]        r_rem  [0:DIV_STEPS][0:3];
    logic [Q_W-1:0]        r_quo  [0:DIV_STEPS][0:3];
    logic                  r_dneg [0:DIV_STEPS][0:3];
    logic [D_W-1:0]        r_dd   [0:DIV_STEPS];
    logic                  r_dz   [0:DIV_STEPS];

    logic                  r_out_valid;
    t_wheels               r_out;
    logic [15:0]           n_res [0:3];

    assign w_adv       = !r_out_valid || o_wheels.ready;
    assign i_cmd.ready = w_adv;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RESET;
        end else if (i_cfg.valid) begin
            r_gain <= i_cfg.payload;
        end
    end

    // entry: angle to Q16, fold by a half turn, rotation term
    always_comb begin
        n_ang  = $signed({i_cmd.payload.heading[15], i_cmd.payload.heading, 3'b000});
        n_z    = n_ang;
        n_flip = 1'b0;
        if (n_ang > ANG_HALF_PI) begin
            n_z    = n_ang - ANG_PI;
            n_flip = 1'b1;
        end else if (n_ang < -ANG_HALF_PI) begin
            n_z    = n_ang + ANG_PI;
            n_flip = 1'b1;
        end
        n_rot = $signed(i_cmd.payload.rotation) * $signed({1'b0, r_gain});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv[0] <= 1'b0;
        end else if (w_adv) begin
            r_cv[0] <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_cx[0] <= CORDIC_START;
            r_cy[0] <= '0;
            r_cz[0] <= n_z;
            r_cf[0] <= n_flip;
            r_cs[0] <= i_cmd.payload.speed;
            r_cr[0] <= n_rot;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cv[i+1] <= 1'b0;
            end else if (w_adv) begin
                r_cv[i+1] <= r_cv[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                if (r_cz[i] >= 0) begin
                    r_cx[i+1] <= r_cx[i] - (r_cy[i] >>> i);
                    r_cy[i+1] <= r_cy[i] + (r_cx[i] >>> i);
                    r_cz[i+1] <= r_cz[i] - atan_q16(i);
                end else begin
                    r_cx[i+1] <= r_cx[i] + (r_cy[i] >>> i);
                    r_cy[i+1] <= r_cy[i] - (r_cx[i] >>> i);
                    r_cz[i+1] <= r_cz[i] + atan_q16(i);
                end
                r_cf[i+1] <= r_cf[i];
                r_cs[i+1] <= r_cs[i];
                r_cr[i+1] <= r_cr[i];
            end
        end
    end

    // valid chain after the cordic
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
            r_e_v <= 1'b0;
            r_f_v <= 1'b0;
            r_g_v <= 1'b0;
        end else if (w_adv) begin
            r_b_v <= r_cv[CORDIC_STEPS];
            r_c_v <= r_b_v;
            r_d_v <= r_c_v;
            r_e_v <= r_d_v;
            r_f_v <= r_e_v;
            r_g_v <= r_f_v;
        end
    end

    always_comb begin
        n_rt = S_W'(r_c_r) <<< 13;
        n_xe = S_W'(r_c_x);
        n_ye = S_W'(r_c_y);
        for (int l = 0; l < 4; l++) begin
            n_abs[l] = (r_d_sum[l] < 0) ? S_W'(-r_d_sum[l]) : S_W'(r_d_sum[l]);
        end
        // first largest wins, only its value matters
        n_big = r_e_m[0];
        for (int l = 1; l < 4; l++) begin
            if (r_e_m[l] > n_big) begin
                n_big = r_e_m[l];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            // undo the half turn fold
            r_b_c     <= r_cf[CORDIC_STEPS] ? -r_cx[CORDIC_STEPS] : r_cx[CORDIC_STEPS];
            r_b_s     <= r_cf[CORDIC_STEPS] ? -r_cy[CORDIC_STEPS] : r_cy[CORDIC_STEPS];
            r_b_speed <= r_cs[CORDIC_STEPS];
            r_b_r     <= r_cr[CORDIC_STEPS];

            r_c_x     <= $signed({1'b0, r_b_speed}) * r_b_c;
            r_c_y     <= $signed({1'b0, r_b_speed}) * r_b_s;
            r_c_speed <= r_b_speed;
            r_c_r     <= r_b_r;

            r_d_sum[0] <= n_rt - n_xe - n_ye;
            r_d_sum[1] <= n_rt - n_xe + n_ye;
            r_d_sum[2] <= n_rt + n_xe - n_ye;
            r_d_sum[3] <= n_rt + n_xe + n_ye;
            r_d_speed  <= r_c_speed;

            // round Q38 to Q10, half away from zero
            for (int l = 0; l < 4; l++) begin
                r_e_m[l]   <= M_W'((n_abs[l] + (S_W'(1) << 27)) >> 28);
                r_e_neg[l] <= r_d_sum[l] < 0;
            end
            r_e_speed <= r_d_speed;

            for (int l = 0; l < 4; l++) begin
                r_f_a[l]   <= A_W'(r_e_m[l]) * A_W'(r_e_speed);
                r_f_neg[l] <= r_e_neg[l];
            end
            r_f_big  <= n_big;
            r_f_zero <= n_big == '0;

            // quotient of (2a + big) / (2 big) rounds half away from zero
            for (int l = 0; l < 4; l++) begin
                r_rem[0][l]  <= N_W'({r_f_a[l], 1'b0}) + N_W'(r_f_big);
                r_quo[0][l]  <= '0;
                r_dneg[0][l] <= r_f_neg[l];
            end
            r_dd[0] <= D_W'({r_f_big, 1'b0});
            r_dz[0] <= r_f_zero;
        end
    end

    always_comb begin
        r_dv[0] = r_g_v;
    end

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        localparam int SH = DIV_STEPS - 1 - k;
        logic [N_W-1:0] w_trial;
        assign w_trial = N_W'(r_dd[k]) << SH;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k+1] <= 1'b0;
            end else if (w_adv) begin
                r_dv[k+1] <= r_dv[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                for (int l = 0; l < 4; l++) begin
                    if (r_rem[k][l] >= w_trial) begin
                        r_rem[k+1][l] <= r_rem[k][l] - w_trial;
                        r_quo[k+1][l] <= r_quo[k][l] | (Q_W'(1) << SH);
                    end else begin
                        r_rem[k+1][l] <= r_rem[k][l];
                        r_quo[k+1][l] <= r_quo[k][l];
                    end
                    r_dneg[k+1][l] <= r_dneg[k][l];
                end
                r_dd[k+1] <= r_dd[k];
                r_dz[k+1] <= r_dz[k];
            end
        end
    end

    always_comb begin
        for (int l = 0; l < 4; l++) begin
            if (r_dz[DIV_STEPS]) begin
                n_res[l] = '0;
            end else if (r_dneg[DIV_STEPS][l]) begin
                n_res[l] = -{1'b0, r_quo[DIV_STEPS][l]};
            end else begin
                n_res[l] = {1'b0, r_quo[DIV_STEPS][l]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_dv[DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out.front_left_speed  <= n_res[0];
            r_out.front_right_speed <= n_res[1];
            r_out.back_left_speed   <= n_res[2];
            r_out.back_right_speed  <= n_res[3];
        end
    end

    assign o_wheels.valid   = r_out_valid;
    assign o_wheels.payload = r_out;

endmodule

/* verif/tb_top.sv */
// testbench for the omni wheel speed mixer: random commands checked against a mixing predictor
module tb_top;
    import owsm_pkg::*;

    localparam int LATENCY = 39;

    class wheel_scoreboard;
        t_wheels pending[$];
        logic [15:0] gain;
        int errors;

        function new();
            gain = GAIN_RESET;
            errors = 0;
        endfunction

        static function longint floor_shr(longint v, int s);
            return v >>> s;
        endfunction

        static function void cos_sin(longint ang, output longint c, output longint s);
            longint x, y, z, dx, dy, step_ang;
            bit flip;
            x = 652032874;
            y = 0;
            z = ang;
            flip = 0;
            if (z > 102944) begin
                z -= 205887;
                flip = 1;
            end else if (z < -102944) begin
                z += 205887;
                flip = 1;
            end
            for (int i = 0; i < 16; i++) begin
                dx = floor_shr(y, i);
                dy = floor_shr(x, i);
                case (i)
                    0: step_ang = 51472;
                    1: step_ang = 30385;
                    2: step_ang = 16055;
                    3: step_ang = 8150;
                    4: step_ang = 4091;
                    5: step_ang = 2047;
                    6: step_ang = 1024;
                    7: step_ang = 512;
                    8: step_ang = 256;
                    9: step_ang = 128;
                    10: step_ang = 64;
                    11: step_ang = 32;
                    12: step_ang = 16;
                    13: step_ang = 8;
                    14: step_ang = 4;
                    default: step_ang = 2;
                endcase
                if (z >= 0) begin
                    x -= dx;
                    y += dy;
                    z -= step_ang;
                end else begin
                    x += dx;
                    y -= dy;
                    z += step_ang;
                end
            end
            c = flip ? -x : x;
            s = flip ? -y : y;
        endfunction

        static function longint to_q10(longint v);
            if (v >= 0)
                return (v + (64'sd1 <<< 27)) >>> 28;
            return -((-v + (64'sd1 <<< 27)) >>> 28);
        endfunction

        static function longint absval(longint v);
            return v < 0 ? -v : v;
        endfunction

        function void note_cmd(t_cmd cmd);
            longint spd, c, s, x, y, r, big, num, q;
            longint ratio[4];
            int pick;
            t_wheels w;
            logic [15:0] outs[4];
            spd = longint'(cmd.speed);
            cos_sin(longint'($signed(cmd.heading)) * 8, c, s);
            x = spd * c;
            y = spd * s;
            r = longint'($signed(cmd.rotation)) * longint'(gain) * 8192;
            ratio[0] = to_q10(-x - y + r);
            ratio[1] = to_q10(-x + y + r);
            ratio[2] = to_q10(x - y + r);
            ratio[3] = to_q10(x + y + r);
            pick = 0;
            for (int i = 1; i < 4; i++)
                if (absval(ratio[i]) > absval(ratio[pick]))
                    pick = i;
            big = absval(ratio[pick]);
            for (int i = 0; i < 4; i++) begin
                q = 0;
                if (big != 0) begin
                    num = ratio[i] * spd;
                    q = (2 * absval(num) + big) / (2 * big);
                    if (num < 0)
                        q = -q;
                end
                outs[i] = q[15:0];
            end
            w.front_left_speed = outs[0];
            w.front_right_speed = outs[1];
            w.back_left_speed = outs[2];
            w.back_right_speed = outs[3];
            pending.push_back(w);
        endfunction

        function void check_wheels(t_wheels got);
            t_wheels exp;
            if (pending.size() == 0) begin
                $display("%0t: unexpected word %h", $time, got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.front_left_speed !== exp.front_left_speed) begin
                $display("%0t: front_left expected %0d got %0d", $time,
                         $signed(exp.front_left_speed), $signed(got.front_left_speed));
                errors++;
            end
            if (got.front_right_speed !== exp.front_right_speed) begin
                $display("%0t: front_right expected %0d got %0d", $time,
                         $signed(exp.front_right_speed), $signed(got.front_right_speed));
                errors++;
            end
            if (got.back_left_speed !== exp.back_left_speed) begin
                $display("%0t: back_left expected %0d got %0d", $time,
                         $signed(exp.back_left_speed), $signed(got.back_left_speed));
                errors++;
            end
            if (got.back_right_speed !== exp.back_right_speed) begin
                $display("%0t: back_right expected %0d got %0d", $time,
                         $signed(exp.back_right_speed), $signed(got.back_right_speed));
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    owsm_cmd_if   cmd_ch();
    owsm_wheel_if wheel_ch();
    owsm_cfg_if   cfg_ch();

    omni_wheel_speed_mixer dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd_ch.sink),
        .o_wheels (wheel_ch.source),
        .i_cfg    (cfg_ch.sink)
    );

    wheel_scoreboard sb = new();
    bit stall_enable;

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(0, 2);
    endfunction

    task automatic send_cmd(logic [14:0] spd, logic [15:0] hdg, logic [15:0] rot);
        t_cmd cmd;
        int gap;
        cmd.speed = spd;
        cmd.heading = hdg;
        cmd.rotation = rot;
        cmd_ch.valid <= 1'b1;
        cmd_ch.payload <= cmd;
        do @(posedge i_clk); while (!cmd_ch.ready);
        sb.note_cmd(cmd);
        if (stall_enable && $urandom_range(0, 1)) begin
            gap = gap_len();
            if (gap > 0) begin
                cmd_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic write_gain(logic [15:0] g);
        cmd_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.payload <= g;
        do @(posedge i_clk); while (!cfg_ch.ready);
        sb.gain = g;
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic random_phase(int n);
        logic [14:0] spd;
        logic [15:0] hdg, rot;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0: spd = 15'($urandom);
                1: spd = 15'($urandom_range(0, 3));
                default: spd = 15'($urandom_range(0, 25600));
            endcase
            if ($urandom_range(0, 7) == 0)
                hdg = 16'($urandom);
            else
                hdg = 16'($signed($urandom_range(0, 51472)) - 25736);
            case ($urandom_range(0, 5))
                0: rot = 16'd0;
                1: rot = 16'($signed($urandom_range(0, 64)) - 32);
                default: rot = 16'($urandom);
            endcase
            send_cmd(spd, hdg, rot);
        end
    endtask

    // result side: random back-pressure, mostly short holds and a few long ones
    initial begin
        int hold;
        hold = 0;
        wheel_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (wheel_ch.valid && wheel_ch.ready)
                sb.check_wheels(wheel_ch.payload);
            if (hold > 0) begin
                hold--;
                wheel_ch.ready <= 1'b0;
            end else if (stall_enable && $urandom_range(0, 2) == 0) begin
                hold = gap_len();
                wheel_ch.ready <= (hold == 0);
            end else begin
                wheel_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.payload = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.payload = '0;
        stall_enable = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, zero speed, out of range heading, all-zero ratios
        send_cmd(15'd0, 16'd0, 16'd0);
        send_cmd(15'd25600, 16'd0, 16'd0);
        send_cmd(15'd25600, 16'sd25736, 16'd0);
        send_cmd(15'd25600, -16'sd25736, 16'd0);
        send_cmd(15'd25600, 16'sd12868, 16'd0);
        send_cmd(15'd25600, -16'sd12868, 16'd0);
        send_cmd(15'd25600, 16'sd6434, 16'd0);
        send_cmd(15'd32767, 16'h7fff, 16'h7fff);
        send_cmd(15'd32767, 16'h8000, 16'h8000);
        send_cmd(15'd0, 16'd0, 16'h7fff);
        send_cmd(15'd100, 16'd1000, 16'h8000);
        send_cmd(15'd1, 16'd0, 16'd0);
        send_cmd(15'd25600, 16'd0, 16'd1);
        send_cmd(15'h5555, 16'h5555, 16'haaaa);
        send_cmd(15'h2aaa, 16'haaaa, 16'h5555);
        write_gain(16'd0);
        send_cmd(15'd25600, 16'd3000, 16'h7fff);
        send_cmd(15'd0, 16'd3000, 16'h7fff);
        write_gain(16'hffff);
        send_cmd(15'd25600, 16'd3000, 16'h7fff);
        send_cmd(15'd10, 16'h8000, 16'h8000);

        stall_enable = 1;
        random_phase(150);
        write_gain(16'd4096);
        random_phase(120);
        write_gain(16'($urandom));
        random_phase(120);
        write_gain(16'd0);
        random_phase(40);
        write_gain(16'hffff);
        random_phase(70);

        cmd_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end
endmodule
